// ----- hw/rtl/iterated_light_curve_enhance_macros.svh -----
// ----------------------------------------------------------------------------
// iterated_light_curve_enhance_macros: assertion helpers
// concurrent assertion wrappers shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ITERATED_LIGHT_CURVE_ENHANCE_MACROS_SVH
`define ITERATED_LIGHT_CURVE_ENHANCE_MACROS_SVH

// same-cycle implication, quiet while reset is low
`define ILCE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// next-cycle implication, quiet while reset is low
`define ILCE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

// ----- hw/rtl/ilce_pkg.sv -----
// ----------------------------------------------------------------------------
// ilce_pkg: shared types and constants
// fixed-point scales, datapath widths and the constant divider set-up
// ----------------------------------------------------------------------------
package ilce_pkg;

  // port-level field widths
  localparam int PIX_CH     = 3;
  localparam int RAW_W      = 8;
  localparam int CURVE_W    = 12;
  localparam int GAIN_W     = 10;
  localparam int GAIN_RESET = 256;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;
  localparam int CURVE_LSB  = PIX_CH * RAW_W;

  // fixed-point scales: unit level and unit curve strength
  localparam int UNIT_SCALE  = 1020;
  localparam int CURVE_SCALE = 1024;
  localparam int CHAN_MAX    = 255;
  localparam int CURVE_SHIFT = $clog2(CURVE_SCALE);
  // unit scale = odd part times a power of two
  localparam int UNIT_ODD    = 255;
  localparam int UNIT_SHIFT  = $clog2(UNIT_SCALE / UNIT_ODD);
  localparam int STEP        = UNIT_SCALE / CHAN_MAX;
  localparam int STEP_SHIFT  = $clog2(STEP);

  // input normalisation: shift by two then by four
  localparam int NORM_SHIFT  = 2 + 4;
  localparam int NORM_PROD_W = RAW_W + GAIN_W;

  // level held between passes, saturated to +-(2^24-1)
  localparam int LEVEL_W     = 25;
  localparam int LEVEL_LIMIT = (1 << (LEVEL_W - 1)) - 1;

  // one pass of the curve
  localparam int ITER_STAGES = 8;
  localparam int DIFF_W      = LEVEL_W + 1;
  localparam int PROD_W      = 50;
  localparam int SPLIT_LO    = 25;
  localparam int MLO_W       = CURVE_W + SPLIT_LO + 1;
  localparam int MHI_W       = CURVE_W + PROD_W - SPLIT_LO;
  localparam int ACC_W       = 62;
  localparam int DIV_SHIFT   = CURVE_SHIFT + UNIT_SHIFT;
  localparam int T_W         = ACC_W - DIV_SHIFT;

  // quotients beyond +-2^26 saturate anyway, so the dividend is clamped there
  localparam int    QOFS_SHIFT = 26;
  localparam int    QOFS       = 1 << QOFS_SHIFT;
  localparam longint TCLAMP    = longint'(UNIT_ODD) << QOFS_SHIFT;
  localparam int    N_W        = 35;

  // n = h*2^17 + l  ->  n/odd = h*SPLIT_MUL + (h*SPLIT_REM + l)/odd
  localparam int SPLIT_W   = 17;
  localparam int H_W       = N_W - SPLIT_W;
  localparam int SPLIT_MUL = (1 << SPLIT_W) / UNIT_ODD;
  localparam int SPLIT_REM = (1 << SPLIT_W) % UNIT_ODD;
  localparam int R_W       = 20;
  localparam int QH_W      = 28;

  // reciprocal for the narrow remainder, exact for every 20-bit value
  localparam int     RECIP_SHIFT = 28;
  localparam longint RECIP       = (longint'(1) << RECIP_SHIFT) / UNIT_ODD + 1;
  localparam int     RP_W        = 41;
  localparam int     Q1_W        = 13;
  localparam int     Q_W         = 29;
  localparam int     S_W         = 30;

  typedef logic signed [LEVEL_W-1:0] level_t;
  typedef logic signed [CURVE_W-1:0] curve_t;
  typedef logic        [RAW_W-1:0]   pixel_t;

  typedef struct packed {
    logic valid;
    logic last;
  } pipe_ctrl_t;

endpackage

// ----- hw/rtl/iterated_light_curve_enhance.sv -----
// ----------------------------------------------------------------------------
// iterated_light_curve_enhance: repeated light curve on rgb pixel items
// input register, eight-stage pipeline per pass and lane, byte clamp register
// throughput one item per cycle unless the output buffer stalls the pipeline
// reset clears the pipeline valids and output buffer and sets the gain to 256
// ----------------------------------------------------------------------------
module iterated_light_curve_enhance
  import ilce_pkg::*;
#(
  parameter int CHANNELS   = 3,
  parameter int ITERATIONS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tdata: red_raw, green_raw, blue_raw, red_curve, green_curve, blue_curve
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: red_out, green_out, blue_out
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [GAIN_W-1:0]     cfg_data_i
);

  localparam int LAT = ITERATIONS * ITER_STAGES + 2;

  logic [GAIN_W-1:0]            gain_q;
  logic                         en;
  logic                         in_fire;
  logic [LAT-1:0]               vld_q;
  logic [LAT-1:0]               last_q;
  logic [PIX_CH-1:0][RAW_W-1:0] level;
  pipe_ctrl_t                   pipe;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = en;
  assign in_fire       = s_axis_tvalid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_W'(GAIN_RESET);
    end else if (cfg_valid_i) begin
      gain_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_fire};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q <= {last_q[LAT-2:0], s_axis_tlast};
    end
  end

  for (genvar c = 0; c < PIX_CH; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      ilce_lane #(
        .ITERATIONS (ITERATIONS)
      ) u_lane (
        .clk_i   (clk_i),
        .en_i    (en),
        .gain_i  (gain_q),
        .raw_i   (s_axis_tdata[c*RAW_W +: RAW_W]),
        .curve_i ($signed(s_axis_tdata[CURVE_LSB + c*CURVE_W +: CURVE_W])),
        .level_o (level[c])
      );
    end else begin : g_off
      assign level[c] = '0;
    end
  end

  assign pipe.valid = vld_q[LAT-1];
  assign pipe.last  = last_q[LAT-1];

  ilce_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pipe_i     (pipe),
    .level_i    (level),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast),
    .en_o       (en)
  );

endmodule

// ----- hw/rtl/ilce_iter.sv -----
// ----------------------------------------------------------------------------
// ilce_iter: one pass of the light curve
// x <= x + a*x*(x-1) in fixed point, eight stages, divide by constant
// ----------------------------------------------------------------------------
module ilce_iter
  import ilce_pkg::*;
(
  input  logic   clk_i,
  input  logic   en_i,
  input  level_t x_i,
  input  curve_t a_i,
  output level_t x_o
);

  level_t x1_q, x2_q, x3_q, x4_q, x5_q, x6_q, x7_q, x8_q;
  curve_t a1_q;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] p_d, p1_q;
  logic signed [MLO_W-1:0]  mlo_d, mlo2_q;
  logic signed [MHI_W-1:0]  mhi_d, mhi2_q;
  logic signed [ACC_W-1:0]  m_d, m3_q;
  logic signed [T_W-1:0]    t_val, t_clamp;
  logic [N_W-1:0]           n_d, n4_q;
  logic                     lownz4_q, lownz5_q, lownz6_q;
  logic [H_W-1:0]           hi;
  logic [R_W-1:0]           r_d, r5_q, r6_q, rem;
  logic [QH_W-1:0]          qh_d, qh5_q, qh6_q;
  logic [Q1_W-1:0]          q1_d, q16_q;
  logic signed [Q_W-1:0]    q_d, q7_q;
  logic                     inexact_d, inexact7_q;
  logic signed [S_W-1:0]    sum, sum_adj;
  level_t                   x_d;

  // stage 1: x*(x - unit)
  assign diff = DIFF_W'(x_i) - DIFF_W'(UNIT_SCALE);
  assign p_d  = PROD_W'(x_i) * PROD_W'(diff);

  // stage 2: a times the product, split in two halves
  assign mlo_d = MLO_W'(a1_q) * $signed(MLO_W'(p1_q[SPLIT_LO-1:0]));
  assign mhi_d = MHI_W'(a1_q) * MHI_W'($signed(p1_q[PROD_W-1:SPLIT_LO]));

  // stage 3: recombine
  assign m_d = (ACC_W'(mhi2_q) <<< SPLIT_LO) + ACC_W'(mlo2_q);

  // stage 4: floor by the power of two, clamp, bias to non-negative
  assign t_val = $signed(m3_q[ACC_W-1:DIV_SHIFT]);

  always_comb begin
    if (t_val > T_W'(TCLAMP)) begin
      t_clamp = T_W'(TCLAMP);
    end else if (t_val < -T_W'(TCLAMP)) begin
      t_clamp = -T_W'(TCLAMP);
    end else begin
      t_clamp = t_val;
    end
  end

  assign n_d = N_W'(t_clamp + T_W'(TCLAMP));

  // stage 5: fold the high part of the dividend
  assign hi   = n4_q[N_W-1:SPLIT_W];
  assign r_d  = R_W'(hi) * R_W'(SPLIT_REM) + R_W'(n4_q[SPLIT_W-1:0]);
  assign qh_d = QH_W'(hi) * QH_W'(SPLIT_MUL);

  // stage 6: reciprocal on the narrow remainder
  assign q1_d = Q1_W'((RP_W'(r5_q) * RP_W'(RECIP)) >> RECIP_SHIFT);

  // stage 7: floor quotient and exactness
  assign rem       = r6_q - R_W'(q16_q) * R_W'(UNIT_ODD);
  assign inexact_d = lownz6_q | (rem != '0);
  assign q_d       = Q_W'(qh6_q) + Q_W'(q16_q) - Q_W'(QOFS);

  // stage 8: add, round toward zero, saturate
  assign sum     = S_W'(x7_q) + S_W'(q7_q);
  assign sum_adj = sum + S_W'(inexact7_q && (sum < 0));

  always_comb begin
    if (sum_adj > S_W'(LEVEL_LIMIT)) begin
      x_d = level_t'(LEVEL_LIMIT);
    end else if (sum_adj < -S_W'(LEVEL_LIMIT)) begin
      x_d = -level_t'(LEVEL_LIMIT);
    end else begin
      x_d = LEVEL_W'(sum_adj);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q       <= x_i;
      a1_q       <= a_i;
      p1_q       <= p_d;
      x2_q       <= x1_q;
      mlo2_q     <= mlo_d;
      mhi2_q     <= mhi_d;
      x3_q       <= x2_q;
      m3_q       <= m_d;
      x4_q       <= x3_q;
      n4_q       <= n_d;
      lownz4_q   <= |m3_q[DIV_SHIFT-1:0];
      x5_q       <= x4_q;
      r5_q       <= r_d;
      qh5_q      <= qh_d;
      lownz5_q   <= lownz4_q;
      x6_q       <= x5_q;
      r6_q       <= r5_q;
      qh6_q      <= qh5_q;
      q16_q      <= q1_d;
      lownz6_q   <= lownz5_q;
      x7_q       <= x6_q;
      q7_q       <= q_d;
      inexact7_q <= inexact_d;
      x8_q       <= x_d;
    end
  end

  assign x_o = x8_q;

endmodule

// ----- hw/rtl/ilce_lane.sv -----
// ----------------------------------------------------------------------------
// ilce_lane: one colour channel
// gain normalisation, a chain of curve passes and the final byte clamp
// ----------------------------------------------------------------------------
module ilce_lane
  import ilce_pkg::*;
#(
  parameter int ITERATIONS = 8
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [GAIN_W-1:0] gain_i,
  input  pixel_t            raw_i,
  input  curve_t            curve_i,
  output pixel_t            level_o
);

  logic [NORM_PROD_W-1:0] norm_prod;
  level_t                 x0_q;
  curve_t                 a0_q;
  level_t                 x_chain [ITERATIONS+1];
  curve_t                 a_tap   [ITERATIONS];
  level_t                 x_fin, x_step;
  pixel_t                 level_d, level_q;

  assign norm_prod = NORM_PROD_W'(raw_i) * NORM_PROD_W'(gain_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q <= $signed(LEVEL_W'(norm_prod[NORM_PROD_W-1:NORM_SHIFT]));
      a0_q <= curve_i;
    end
  end

  assign x_chain[0] = x0_q;
  assign a_tap[0]   = a0_q;

  // curve strength follows each item down the chain of passes
  for (genvar k = 1; k < ITERATIONS; k++) begin : g_adly
    curve_t dly_q [ITER_STAGES];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dly_q[0] <= a_tap[k-1];
        for (int j = 1; j < ITER_STAGES; j++) begin
          dly_q[j] <= dly_q[j-1];
        end
      end
    end

    assign a_tap[k] = dly_q[ITER_STAGES-1];
  end

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_pass
    ilce_iter u_iter (
      .clk_i (clk_i),
      .en_i  (en_i),
      .x_i   (x_chain[k]),
      .a_i   (a_tap[k]),
      .x_o   (x_chain[k+1])
    );
  end

  assign x_fin  = x_chain[ITERATIONS];
  assign x_step = x_fin >>> STEP_SHIFT;

  always_comb begin
    if (x_fin < 0) begin
      level_d = '0;
    end else if (x_step > level_t'(CHAN_MAX)) begin
      level_d = RAW_W'(CHAN_MAX);
    end else begin
      level_d = x_step[RAW_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

// ----- hw/rtl/ilce_merge.sv -----
// ----------------------------------------------------------------------------
// ilce_merge: lane merge and output buffer
// packs the channel bytes into one item, output register plus skid stage
// ----------------------------------------------------------------------------
module ilce_merge
  import ilce_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pipe_ctrl_t                   pipe_i,
  input  logic [PIX_CH-1:0][RAW_W-1:0] level_i,
  input  logic                         m_tready_i,
  output logic                         m_tvalid_o,
  output logic [OUT_DATA_W-1:0]        m_tdata_o,
  output logic                         m_tlast_o,
  output logic                         en_o
);

  logic                  out_valid_d, out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_d, out_data_q;
  logic                  out_last_d, out_last_q;
  logic                  skid_valid_d, skid_valid_q;
  logic [OUT_DATA_W-1:0] skid_data_d, skid_data_q;
  logic                  skid_last_d, skid_last_q;
  logic [OUT_DATA_W-1:0] merged;
  logic                  arrive;

  assign merged = OUT_DATA_W'(level_i);
  // the pipeline only moves while the skid stage is empty
  assign en_o   = !skid_valid_q;
  assign arrive = pipe_i.valid && en_o;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    skid_last_d  = skid_last_q;
    if (!out_valid_q || m_tready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        out_last_d   = skid_last_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = arrive;
        out_data_d  = merged;
        out_last_d  = pipe_i.last;
      end
    end else if (arrive) begin
      skid_valid_d = 1'b1;
      skid_data_d  = merged;
      skid_last_d  = pipe_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_last_q  <= out_last_d;
    skid_data_q <= skid_data_d;
    skid_last_q <= skid_last_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

endmodule

// ----- hw/rtl/ilce_checker.sv -----
// ----------------------------------------------------------------------------
// ilce_checker: port-level checks
// output hold and input back-pressure behaviour seen at the top level
// ----------------------------------------------------------------------------
`include "iterated_light_curve_enhance_macros.svh"

module ilce_checker
  import ilce_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready
);

  // a stalled output item stays put
  `ILCE_ASSERT_NEXT(out_hold_a, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // input is held off only while the output holds a valid item
  `ILCE_ASSERT_IMPL(stall_backlog_a, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid)

  // back-pressure starts only after a refused output item
  `ILCE_ASSERT_IMPL(stall_cause_a, clk_i, rst_ni, $fell(s_axis_tready), $past(m_axis_tvalid && !m_axis_tready))

  // one taken output item frees the input again
  `ILCE_ASSERT_NEXT(stall_clear_a, clk_i, rst_ni, !s_axis_tready && m_axis_tready, s_axis_tready)

endmodule

bind iterated_light_curve_enhance ilce_checker u_ilce_checker (.*);

// ----- tb/iterated_light_curve_enhance_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterated_light_curve_enhance_test: self-checking bench for the curve block
// drives pixel items from a directed table and then random phases with
// varied gain, sender gaps and receiver stalls, and checks every output item
// field by field against a table value or a predictor of the curve arithmetic
// ----------------------------------------------------------------------------
module iterated_light_curve_enhance_test;
  import ilce_pkg::*;

  localparam int PASSES      = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 100;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;

  typedef struct packed {
    logic                             last;
    logic [PIX_CH-1:0][CURVE_W-1:0]   curve;
    logic [PIX_CH-1:0][RAW_W-1:0]     raw;
  } pixel_item_t;

  typedef struct packed {
    logic                             last;
    logic [PIX_CH-1:0][RAW_W-1:0]     chan;
  } pixel_result_t;

  // raw, curve and want hold {blue, green, red}
  typedef struct packed {
    logic [GAIN_W-1:0]         gain;
    logic [PIX_CH*RAW_W-1:0]   raw;
    logic [PIX_CH*CURVE_W-1:0] curve;
    logic                      last;
    logic                      typed;
    logic [PIX_CH*RAW_W-1:0]   want;
  } plan_row_t;

  localparam int PLAN_LEN = 20;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{10'd256,  24'h000000, 36'h000000000, 1'b0, 1'b1, 24'h000000},
    '{10'd256,  24'hFFFFFF, 36'h000000000, 1'b0, 1'b1, 24'hFFFFFF},
    '{10'd256,  24'h800140, 36'h000000000, 1'b1, 1'b1, 24'h800140},
    // unit level and zero level are fixed points of the curve
    '{10'd256,  24'hFFFFFF, 36'h7FF7FF7FF, 1'b0, 1'b1, 24'hFFFFFF},
    '{10'd256,  24'h000000, 36'h800800800, 1'b0, 1'b1, 24'h000000},
    '{10'd256,  24'hA55AC3, 36'h400400400, 1'b0, 1'b0, 24'h000000},
    '{10'd256,  24'h102030, 36'hC00C00C00, 1'b0, 1'b0, 24'h000000},
    '{10'd256,  24'h7F3F1F, 36'h7FF800001, 1'b1, 1'b0, 24'h000000},
    '{10'd256,  24'hFF00FF, 36'h800000400, 1'b0, 1'b0, 24'h000000},
    // large gain: clamp high, runaway negative and runaway positive
    '{10'd1023, 24'hFFFFFF, 36'h000000000, 1'b0, 1'b1, 24'hFFFFFF},
    '{10'd1023, 24'hFFFFFF, 36'h800800800, 1'b0, 1'b1, 24'h000000},
    '{10'd1023, 24'hFFFFFF, 36'h7FF7FF7FF, 1'b1, 1'b1, 24'hFFFFFF},
    '{10'd1023, 24'h808080, 36'hC00C00C00, 1'b0, 1'b0, 24'h000000},
    '{10'd1023, 24'h030201, 36'h5A3A5C123, 1'b0, 1'b0, 24'h000000},
    '{10'd0,    24'hFFFFFF, 36'h7FF800400, 1'b1, 1'b1, 24'h000000},
    '{10'd0,    24'hA5A5A5, 36'h800800800, 1'b0, 1'b1, 24'h000000},
    '{10'd1,    24'hFFFFFF, 36'h000000000, 1'b0, 1'b0, 24'h000000},
    '{10'd512,  24'h404040, 36'h400C00400, 1'b0, 1'b0, 24'h000000},
    '{10'd512,  24'hFFFFFF, 36'h000000000, 1'b1, 1'b0, 24'h000000},
    '{10'd256,  24'h010203, 36'h000000000, 1'b0, 1'b1, 24'h010203}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [GAIN_W-1:0]     cfg_data      = '0;

  logic              hold_output  = 1'b0;
  logic [GAIN_W-1:0] gain_setting = GAIN_W'(GAIN_RESET);
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                mismatches     = 0;
  int                cycle_count    = 0;
  pixel_result_t     expected_pixels [$];

  always #2 clk_i = ~clk_i;

  iterated_light_curve_enhance #(
    .CHANNELS   (PIX_CH),
    .ITERATIONS (PASSES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  // one channel: normalise, run the curve passes, scale back to a byte
  function automatic pixel_t curve_channel(input pixel_t raw, input curve_t strength,
                                           input logic [GAIN_W-1:0] gain);
    longint level;
    longint lin;
    longint acc;
    longint a;
    int     pass;
    a     = longint'(strength);
    level = ((longint'(raw) * longint'(gain)) >> 2) >> 4;
    for (pass = 0; pass < PASSES; pass++) begin
      lin   = level * UNIT_SCALE;
      acc   = lin * CURVE_SCALE + a * (level * level - lin);
      level = acc / (longint'(UNIT_SCALE) * CURVE_SCALE);
      if (level > LEVEL_LIMIT) begin
        level = LEVEL_LIMIT;
      end else if (level < -LEVEL_LIMIT) begin
        level = -LEVEL_LIMIT;
      end
    end
    level = level / (UNIT_SCALE / CHAN_MAX);
    if (level > CHAN_MAX) begin
      level = CHAN_MAX;
    end else if (level < 0) begin
      level = 0;
    end
    return pixel_t'(level);
  endfunction

  function automatic pixel_result_t predict_pixel(input pixel_item_t item);
    pixel_result_t res;
    int            c;
    res.last = item.last;
    for (c = 0; c < PIX_CH; c++) begin
      res.chan[c] = curve_channel(item.raw[c], item.curve[c], gain_setting);
    end
    return res;
  endfunction

  function automatic pixel_item_t random_pixel();
    pixel_item_t item;
    int          c;
    for (c = 0; c < PIX_CH; c++) begin
      case ($urandom_range(9))
        0: item.raw[c] = '0;
        1: item.raw[c] = '1;
        default: item.raw[c] = RAW_W'($urandom);
      endcase
      // mostly within +-1.0, now and then anywhere in the 12-bit range
      case ($urandom_range(9))
        0: item.curve[c] = CURVE_W'($urandom);
        1: item.curve[c] = CURVE_W'(CURVE_SCALE);
        2: item.curve[c] = CURVE_W'(-CURVE_SCALE);
        default: item.curve[c] = CURVE_W'($urandom_range(2 * CURVE_SCALE) - CURVE_SCALE);
      endcase
    end
    item.last = ($urandom_range(15) == 0);
    return item;
  endfunction

  task automatic offer_pixel(input pixel_item_t item, input logic typed,
                             input pixel_result_t typed_result);
    pixel_result_t outcome;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({item.curve, item.raw});
    s_axis_tlast  <= item.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    outcome = typed ? typed_result : predict_pixel(item);
    expected_pixels.push_back(outcome);
  endtask

  // gain changes only once the pipeline has drained
  task automatic write_gain(input logic [GAIN_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid    <= 1'b0;
    gain_setting = value;
  endtask

  always @(posedge clk_i) begin : sink
    pixel_result_t got;
    pixel_result_t want;
    logic          bad;
    int            c;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tlast, m_axis_tdata};
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected output item: r %0d g %0d b %0d last %0d",
                   got.chan[0], got.chan[1], got.chan[2], got.last);
        end
      end else begin
        want = expected_pixels.pop_front();
        bad  = (got.last !== want.last);
        for (c = 0; c < PIX_CH; c++) begin
          if (got.chan[c] !== want.chan[c]) bad = 1'b1;
        end
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected r %0d g %0d b %0d last %0d, got r %0d g %0d b %0d last %0d",
                     want.chan[0], want.chan[1], want.chan[2], want.last,
                     got.chan[0], got.chan[1], got.chan[2], got.last);
          end
        end
      end
    end
    if (hold_output) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("iterated_light_curve_enhance_test NOT OK");
      $finish;
    end
  end

  initial begin
    pixel_item_t       item;
    logic [GAIN_W-1:0] gain;
    int                i;
    int                ph;
    int                n;
    int                count;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].gain != gain_setting) write_gain(PLAN[i].gain);
      item.raw   = PLAN[i].raw;
      item.curve = PLAN[i].curve;
      item.last  = PLAN[i].last;
      offer_pixel(item, PLAN[i].typed, {PLAN[i].last, PLAN[i].want});
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: gain = '1;
        1: gain = GAIN_W'(GAIN_RESET);
        2: gain = '0;
        5: gain = GAIN_W'(1);
        7: gain = GAIN_W'(512);
        default: gain = GAIN_W'($urandom_range(1023));
      endcase
      write_gain(gain);
      // no idling, sender gaps, receiver stalls, then both
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      // a long output hold-off so the pipeline fills and the input stalls
      if (ph == 4) begin
        fork
          begin
            hold_output <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            hold_output <= 1'b0;
          end
        join_none
      end
      count = (gain == 0) ? 30 : 150;
      for (n = 0; n < count; n++) begin
        offer_pixel(random_pixel(), 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("iterated_light_curve_enhance_test OK");
    end else begin
      $display("iterated_light_curve_enhance_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- iterated_light_curve_enhance.f -----
+incdir+hw/rtl
hw/rtl/ilce_pkg.sv
hw/rtl/ilce_iter.sv
hw/rtl/ilce_lane.sv
hw/rtl/ilce_merge.sv
hw/rtl/iterated_light_curve_enhance.sv
hw/rtl/ilce_checker.sv
tb/iterated_light_curve_enhance_test.sv
